// File: sv/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define SPH_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define SPH_ASSERT_NR(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: sv/sph_pkg.sv
// Shared types, constants and rotation tables of the stream hash block.
package sph_pkg;

	localparam int unsigned BUF_WORDS   = 24;
	localparam int unsigned BUF_BYTES   = 192;
	localparam int unsigned BLOCK_WORDS = 12;
	localparam int unsigned BLOCK_BYTES = 96;

	localparam logic [63:0] CONST_RESET = 64'hdeadbeefdeadbeef;

	localparam logic [1:0] CFG_SEED_FIRST  = 2'd0;
	localparam logic [1:0] CFG_SEED_SECOND = 2'd1;
	localparam logic [1:0] CFG_CONST       = 2'd2;

	localparam logic [5:0] MIX_ROT [12] = '{6'd11, 6'd32, 6'd43, 6'd31, 6'd17, 6'd28,
		6'd39, 6'd57, 6'd55, 6'd54, 6'd22, 6'd46};
	localparam logic [5:0] ENDP_ROT [12] = '{6'd44, 6'd15, 6'd34, 6'd21, 6'd38, 6'd33,
		6'd10, 6'd13, 6'd38, 6'd53, 6'd42, 6'd54};
	localparam logic [5:0] SMIX_ROT [12] = '{6'd50, 6'd52, 6'd30, 6'd41, 6'd54, 6'd48,
		6'd38, 6'd37, 6'd62, 6'd34, 6'd5, 6'd36};
	localparam logic [5:0] SEND_ROT [11] = '{6'd15, 6'd52, 6'd26, 6'd51, 6'd28, 6'd9,
		6'd47, 6'd54, 6'd32, 6'd25, 6'd63};

	typedef enum logic [1:0] {ALU_ADD, ALU_XOR, ALU_ROL} alu_op_t;
	typedef enum logic [1:0] {B_STATE, B_DATA, B_LEN, B_CONST} bsrc_t;
	typedef enum logic [1:0] {ROT_NONE, ROT_12, ROT_4} rmode_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_APPEND, ST_LOAD, ST_MIX, ST_FIN, ST_SINIT, ST_SDEC, ST_SA,
		ST_SMIX, ST_SB, ST_STAIL, ST_SEND, ST_LADD, ST_ENDP, ST_DONE
	} state_t;

	typedef struct packed {
		logic        en;
		logic [7:0]  pos;
		logic [3:0]  take;
		logic [63:0] data;
	} buf_wr_t;

	typedef struct packed {
		alu_op_t     alu_op;
		logic [3:0]  a_pos;
		bsrc_t       b_src;
		logic [3:0]  b_pos;
		logic [3:0]  dst_pos;
		logic        wr_en;
		logic [5:0]  rot_k;
		rmode_t      rot_mode;
		logic        load_long;
		logic        load_short;
		logic [4:0]  rd_idx;
		logic [3:0]  rd_keep;
		logic        rd_top_en;
		logic [7:0]  rd_top_val;
		logic [7:0]  len;
		logic        out_load;
		logic        short_sel;
	} ctrl_t;

endpackage

// File: sv/sph_alu.sv
// Shared 64-bit add / xor / rotate-left unit.
module sph_alu (
	input  sph_pkg::alu_op_t op,
	input  logic [63:0]      a,
	input  logic [63:0]      b,
	input  logic [5:0]       k,
	output logic [63:0]      y
);
	logic [127:0] wide;

	assign wide = {a, a} << k;

	always_comb begin
		unique case (op)
			sph_pkg::ALU_ADD: y = a + b;
			sph_pkg::ALU_XOR: y = a ^ b;
			sph_pkg::ALU_ROL: y = wide[127:64];
			default:          y = a;
		endcase
	end
endmodule

// File: sv/sph_buf.sv
// 192-byte tail buffer: byte-granular append, one masked word read.
module sph_buf (
	input  logic             clk,
	input  sph_pkg::buf_wr_t wr,
	input  logic [4:0]       rd_idx,
	input  logic [3:0]       rd_keep,
	input  logic             rd_top_en,
	input  logic [7:0]       rd_top_val,
	output logic [63:0]      rd_data
);
	logic [63:0]  mem_q [sph_pkg::BUF_WORDS];
	logic [4:0]   hi;
	logic [4:0]   hi1;
	logic [2:0]   sh;
	logic [8:0]   m9;
	logic [15:0]  be;
	logic [127:0] dsh;
	logic [63:0]  raw;

	assign hi  = wr.pos[7:3];
	assign hi1 = hi + 5'd1;
	assign sh  = wr.pos[2:0];
	assign m9  = (9'd1 << wr.take) - 9'd1;
	assign be  = {8'd0, m9[7:0]} << sh;
	assign dsh = {64'd0, wr.data} << {sh, 3'b000};

	// a word may straddle two buffer words
	always_ff @(posedge clk) begin
		if (wr.en) begin
			for (int b = 0; b < 8; b++) begin
				if (be[b])
					mem_q[hi][8*b +: 8] <= dsh[8*b +: 8];
				if (be[8+b] && hi != 5'(sph_pkg::BUF_WORDS - 1))
					mem_q[hi1][8*b +: 8] <= dsh[64 + 8*b +: 8];
			end
		end
	end

	assign raw = (rd_idx < 5'(sph_pkg::BUF_WORDS)) ? mem_q[rd_idx] : 64'd0;

	always_comb begin
		for (int j = 0; j < 8; j++)
			rd_data[8*j +: 8] = (4'(j) < rd_keep) ? raw[8*j +: 8] : 8'd0;
		if (rd_top_en)
			rd_data[63:56] = rd_top_val;
	end
endmodule

// File: sv/sph_seq.sv
// Sequencer: input capture, byte counts and micro-op control for the shared unit.
module sph_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [63:0]      data_word,
	input  logic [3:0]       byte_count,
	input  logic             last,
	input  logic             out_busy,
	output sph_pkg::buf_wr_t bwr,
	output sph_pkg::ctrl_t   ctl
);
	sph_pkg::state_t state_q, state_nx;

	logic [63:0] word_q;
	logic [3:0]  cnt_q;
	logic        last_q;
	logic [7:0]  buf_q;
	logic [63:0] total_q;
	logic [3:0]  step_q;
	logic [2:0]  ph_q;
	logic [1:0]  rnd_q;
	logic [1:0]  sub_q;
	logic        blk_q;
	logic        full_q;
	logic        short_q;
	logic        fin_q;
	logic        lbase_q;
	logic [4:0]  pos_q;
	logic [7:0]  rem_q;

	logic [7:0]  space;
	logic [3:0]  take;
	logic [7:0]  buf_nx;
	logic [63:0] tot_nx;
	logic        full_hit;
	logic        first_fill;
	logic [7:0]  lr;
	logic [7:0]  lo;
	logic [7:0]  rem_m8;
	logic [3:0]  cnt_in;
	logic        mix_end;
	logic        ph3_end;

	assign space      = 8'(sph_pkg::BUF_BYTES) - buf_q;
	assign take       = ({4'd0, cnt_q} < space) ? cnt_q : space[3:0];
	assign buf_nx     = buf_q + {4'd0, take};
	assign tot_nx     = total_q + {60'd0, take};
	assign full_hit   = buf_nx == 8'(sph_pkg::BUF_BYTES);
	assign first_fill = tot_nx <= 64'(sph_pkg::BUF_BYTES);
	assign lr         = lbase_q ? buf_q - 8'(sph_pkg::BLOCK_BYTES) : buf_q;
	assign lo         = {1'b0, step_q, 3'b000};
	assign rem_m8     = rem_q - 8'd8;
	assign cnt_in     = (byte_count > 4'd8) ? 4'd8 : byte_count;
	assign mix_end    = ph_q == 3'd4 && step_q == 4'd11;
	assign ph3_end    = ph_q == 3'd2;

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			sph_pkg::ST_IDLE:   if (in_valid) state_nx = sph_pkg::ST_APPEND;
			sph_pkg::ST_APPEND: begin
				if (full_hit)
					state_nx = first_fill ? sph_pkg::ST_LOAD : sph_pkg::ST_MIX;
				else
					state_nx = last_q ? sph_pkg::ST_FIN : sph_pkg::ST_IDLE;
			end
			sph_pkg::ST_LOAD:   state_nx = sph_pkg::ST_MIX;
			sph_pkg::ST_MIX: begin
				if (mix_end) begin
					if (fin_q)
						state_nx = sph_pkg::ST_LADD;
					else if (blk_q)
						state_nx = sph_pkg::ST_APPEND;
				end
			end
			sph_pkg::ST_FIN: begin
				if (total_q < 64'(sph_pkg::BUF_BYTES))
					state_nx = sph_pkg::ST_SINIT;
				else if (buf_q >= 8'(sph_pkg::BLOCK_BYTES))
					state_nx = sph_pkg::ST_MIX;
				else
					state_nx = sph_pkg::ST_LADD;
			end
			sph_pkg::ST_SINIT:  state_nx = sph_pkg::ST_SDEC;
			sph_pkg::ST_SDEC:   state_nx = (rem_q >= 8'd16) ? sph_pkg::ST_SA : sph_pkg::ST_STAIL;
			sph_pkg::ST_SA:     if (sub_q == 2'd1) state_nx = sph_pkg::ST_SMIX;
			sph_pkg::ST_SMIX: begin
				if (ph3_end && step_q == 4'd11)
					state_nx = full_q ? sph_pkg::ST_SB : sph_pkg::ST_SDEC;
			end
			sph_pkg::ST_SB:     if (sub_q == 2'd1) state_nx = sph_pkg::ST_SDEC;
			sph_pkg::ST_STAIL:  if (sub_q == 2'd2) state_nx = sph_pkg::ST_SEND;
			sph_pkg::ST_SEND:   if (ph3_end && step_q == 4'd10) state_nx = sph_pkg::ST_DONE;
			sph_pkg::ST_LADD:   if (step_q == 4'd11) state_nx = sph_pkg::ST_ENDP;
			sph_pkg::ST_ENDP: begin
				if (ph3_end && step_q == 4'd11 && rnd_q == 2'd2)
					state_nx = sph_pkg::ST_DONE;
			end
			sph_pkg::ST_DONE:   if (!out_busy) state_nx = sph_pkg::ST_IDLE;
			default:            state_nx = sph_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sph_pkg::ST_IDLE;
			cnt_q   <= '0;
			last_q  <= 1'b0;
			buf_q   <= '0;
			total_q <= '0;
			step_q  <= '0;
			ph_q    <= '0;
			rnd_q   <= '0;
			sub_q   <= '0;
			blk_q   <= 1'b0;
			full_q  <= 1'b0;
			short_q <= 1'b0;
			fin_q   <= 1'b0;
			lbase_q <= 1'b0;
			pos_q   <= '0;
			rem_q   <= '0;
		end else begin
			state_q <= state_nx;
			case (state_q)
				sph_pkg::ST_IDLE: begin
					if (in_valid) begin
						cnt_q  <= cnt_in;
						last_q <= last;
					end
				end
				sph_pkg::ST_APPEND: begin
					buf_q   <= full_hit ? 8'd0 : buf_nx;
					total_q <= tot_nx;
					cnt_q   <= cnt_q - take;
					step_q  <= '0;
					ph_q    <= '0;
					blk_q   <= 1'b0;
				end
				sph_pkg::ST_MIX: begin
					if (ph_q == 3'd4) begin
						ph_q <= '0;
						if (step_q == 4'd11) begin
							step_q <= '0;
							blk_q  <= ~blk_q;
						end else begin
							step_q <= step_q + 4'd1;
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				sph_pkg::ST_FIN: begin
					short_q <= total_q < 64'(sph_pkg::BUF_BYTES);
					rem_q   <= total_q[7:0];
					pos_q   <= '0;
					step_q  <= '0;
					ph_q    <= '0;
					blk_q   <= 1'b0;
					if (total_q >= 64'(sph_pkg::BUF_BYTES)
						&& buf_q >= 8'(sph_pkg::BLOCK_BYTES)) begin
						fin_q   <= 1'b1;
						lbase_q <= 1'b1;
					end else begin
						lbase_q <= 1'b0;
					end
				end
				sph_pkg::ST_SDEC: begin
					full_q <= rem_q >= 8'd32;
					sub_q  <= '0;
				end
				sph_pkg::ST_SA, sph_pkg::ST_SB: begin
					if (sub_q == 2'd1) begin
						sub_q  <= '0;
						step_q <= '0;
						ph_q   <= '0;
						if (state_q == sph_pkg::ST_SB) begin
							pos_q <= pos_q + 5'd4;
							rem_q <= rem_q - 8'd32;
						end
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
				sph_pkg::ST_SMIX, sph_pkg::ST_SEND: begin
					if (ph3_end) begin
						ph_q   <= '0;
						step_q <= (step_q == 4'd11) ? 4'd0 : step_q + 4'd1;
						// half group consumed 16 bytes
						if (state_q == sph_pkg::ST_SMIX && step_q == 4'd11 && !full_q) begin
							pos_q <= pos_q + 5'd2;
							rem_q <= rem_q - 8'd16;
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				sph_pkg::ST_STAIL: begin
					if (sub_q == 2'd2) begin
						sub_q  <= '0;
						step_q <= '0;
						ph_q   <= '0;
					end else begin
						sub_q <= sub_q + 2'd1;
					end
				end
				sph_pkg::ST_LADD: begin
					step_q <= (step_q == 4'd11) ? 4'd0 : step_q + 4'd1;
					ph_q   <= '0;
					rnd_q  <= '0;
				end
				sph_pkg::ST_ENDP: begin
					if (ph3_end) begin
						ph_q <= '0;
						if (step_q == 4'd11) begin
							step_q <= '0;
							rnd_q  <= rnd_q + 2'd1;
						end else begin
							step_q <= step_q + 4'd1;
						end
					end else begin
						ph_q <= ph_q + 3'd1;
					end
				end
				sph_pkg::ST_DONE: begin
					if (!out_busy) begin
						total_q <= '0;
						buf_q   <= '0;
						fin_q   <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	// consumed bytes shift out of the low end
	always_ff @(posedge clk) begin
		if (state_q == sph_pkg::ST_IDLE && in_valid)
			word_q <= data_word;
		else if (state_q == sph_pkg::ST_APPEND)
			word_q <= word_q >> {take, 3'b000};
	end

	always_comb begin
		in_ready     = state_q == sph_pkg::ST_IDLE;
		bwr.en       = state_q == sph_pkg::ST_APPEND;
		bwr.pos      = buf_q;
		bwr.take     = take;
		bwr.data     = word_q;
		ctl          = '0;
		ctl.alu_op   = sph_pkg::ALU_ADD;
		ctl.b_src    = sph_pkg::B_STATE;
		ctl.rot_mode = sph_pkg::ROT_NONE;
		ctl.len      = total_q[7:0];
		ctl.short_sel = short_q;
		unique case (state_q)
			sph_pkg::ST_LOAD:  ctl.load_long = 1'b1;
			sph_pkg::ST_SINIT: ctl.load_short = 1'b1;
			sph_pkg::ST_MIX: begin
				ctl.wr_en   = 1'b1;
				ctl.rd_idx  = (blk_q ? 5'd12 : 5'd0) + {1'b0, step_q};
				ctl.rd_keep = 4'd8;
				unique case (ph_q)
					3'd0: begin
						ctl.b_src = sph_pkg::B_DATA;
					end
					3'd1: begin
						ctl.alu_op = sph_pkg::ALU_XOR;
						ctl.a_pos = 4'd2; ctl.b_pos = 4'd10; ctl.dst_pos = 4'd2;
					end
					3'd2: begin
						ctl.alu_op = sph_pkg::ALU_XOR;
						ctl.a_pos = 4'd11; ctl.b_pos = 4'd0; ctl.dst_pos = 4'd11;
					end
					3'd3: begin
						ctl.alu_op = sph_pkg::ALU_ROL;
						ctl.rot_k  = sph_pkg::MIX_ROT[step_q];
					end
					default: begin
						ctl.a_pos = 4'd11; ctl.b_pos = 4'd1; ctl.dst_pos = 4'd11;
						ctl.rot_mode = sph_pkg::ROT_12;
					end
				endcase
			end
			sph_pkg::ST_SA: begin
				ctl.wr_en   = 1'b1;
				ctl.b_src   = sph_pkg::B_DATA;
				ctl.rd_idx  = pos_q + {4'd0, sub_q[0]};
				ctl.rd_keep = 4'd8;
				ctl.a_pos   = 4'd2 + {3'd0, sub_q[0]};
				ctl.dst_pos = 4'd2 + {3'd0, sub_q[0]};
			end
			sph_pkg::ST_SB: begin
				ctl.wr_en   = 1'b1;
				ctl.b_src   = sph_pkg::B_DATA;
				ctl.rd_idx  = pos_q + 5'd2 + {4'd0, sub_q[0]};
				ctl.rd_keep = 4'd8;
				ctl.a_pos   = {3'd0, sub_q[0]};
				ctl.dst_pos = {3'd0, sub_q[0]};
			end
			sph_pkg::ST_SMIX: begin
				ctl.wr_en = 1'b1;
				unique case (ph_q)
					3'd0: begin
						ctl.alu_op = sph_pkg::ALU_ROL;
						ctl.a_pos = 4'd2; ctl.dst_pos = 4'd2;
						ctl.rot_k = sph_pkg::SMIX_ROT[step_q];
					end
					3'd1: begin
						ctl.a_pos = 4'd2; ctl.b_pos = 4'd3; ctl.dst_pos = 4'd2;
					end
					default: begin
						ctl.alu_op = sph_pkg::ALU_XOR;
						ctl.a_pos = 4'd0; ctl.b_pos = 4'd2; ctl.dst_pos = 4'd0;
						ctl.rot_mode = sph_pkg::ROT_4;
					end
				endcase
			end
			sph_pkg::ST_STAIL: begin
				ctl.wr_en = 1'b1;
				unique case (sub_q)
					2'd0: begin
						ctl.b_src = sph_pkg::B_LEN;
						ctl.a_pos = 4'd3; ctl.dst_pos = 4'd3;
					end
					2'd1: begin
						ctl.b_src   = (rem_q == 8'd0) ? sph_pkg::B_CONST : sph_pkg::B_DATA;
						ctl.rd_idx  = pos_q;
						ctl.rd_keep = (rem_q < 8'd8) ? rem_q[3:0] : 4'd8;
						ctl.a_pos = 4'd2; ctl.dst_pos = 4'd2;
					end
					default: begin
						ctl.b_src   = (rem_q == 8'd0) ? sph_pkg::B_CONST : sph_pkg::B_DATA;
						ctl.rd_idx  = pos_q + 5'd1;
						ctl.rd_keep = (rem_q > 8'd8) ? rem_m8[3:0] : 4'd0;
						ctl.a_pos = 4'd3; ctl.dst_pos = 4'd3;
					end
				endcase
			end
			sph_pkg::ST_SEND: begin
				ctl.wr_en = 1'b1;
				unique case (ph_q)
					3'd0: begin
						ctl.alu_op = sph_pkg::ALU_XOR;
						ctl.a_pos = 4'd3; ctl.b_pos = 4'd2; ctl.dst_pos = 4'd3;
					end
					3'd1: begin
						ctl.alu_op = sph_pkg::ALU_ROL;
						ctl.a_pos = 4'd2; ctl.dst_pos = 4'd2;
						ctl.rot_k = sph_pkg::SEND_ROT[step_q];
					end
					default: begin
						ctl.a_pos = 4'd3; ctl.b_pos = 4'd2; ctl.dst_pos = 4'd3;
						ctl.rot_mode = sph_pkg::ROT_4;
					end
				endcase
			end
			sph_pkg::ST_LADD: begin
				ctl.wr_en      = 1'b1;
				ctl.b_src      = sph_pkg::B_DATA;
				ctl.rot_mode   = sph_pkg::ROT_12;
				ctl.rd_idx     = (lbase_q ? 5'd12 : 5'd0) + {1'b0, step_q};
				ctl.rd_top_en  = step_q == 4'd11;
				ctl.rd_top_val = lr;
				if (lr >= lo + 8'd8)
					ctl.rd_keep = 4'd8;
				else if (lr > lo)
					ctl.rd_keep = 4'(lr - lo);
				else
					ctl.rd_keep = 4'd0;
			end
			sph_pkg::ST_ENDP: begin
				ctl.wr_en = 1'b1;
				unique case (ph_q)
					3'd0: begin
						ctl.a_pos = 4'd11; ctl.b_pos = 4'd1; ctl.dst_pos = 4'd11;
					end
					3'd1: begin
						ctl.alu_op = sph_pkg::ALU_XOR;
						ctl.a_pos = 4'd2; ctl.b_pos = 4'd11; ctl.dst_pos = 4'd2;
					end
					default: begin
						ctl.alu_op = sph_pkg::ALU_ROL;
						ctl.a_pos = 4'd1; ctl.dst_pos = 4'd1;
						ctl.rot_k = sph_pkg::ENDP_ROT[step_q];
						ctl.rot_mode = sph_pkg::ROT_12;
					end
				endcase
			end
			sph_pkg::ST_DONE: ctl.out_load = !out_busy;
			default: ;
		endcase
	end
endmodule

// File: sv/spooky_hash_stream_top.sv
// Stream hash top level: config registers, mix state, shared ALU and result register.
// Word that does not fill the buffer: capture, then append. Filling it adds two 12-step
// block mixes at 5 ops a step on the one ALU, then a second append pass; the first fill
// loads seeds first. Last word adds short path (seed load, 32-byte groups, 16-byte half,
// tail, end steps) or long path (mix if a whole block is buffered, last add, end rounds).
// Async reset clears control, counts and config; a stalled result holds off the next one.
module spooky_hash_stream_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] data_word,
	input  logic [3:0]  byte_count,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] hash,
	input  logic        write_en,
	input  logic [1:0]  write_index,
	input  logic [63:0] write_data
);
	logic [63:0] seed_first_q;
	logic [63:0] seed_second_q;
	logic [63:0] const_q;
	logic [63:0] s_q [12];
	logic [63:0] tmp [12];
	logic [63:0] s_nx [12];
	logic [63:0] op_a;
	logic [63:0] op_b;
	logic [63:0] alu_y;
	logic [63:0] rd_data;
	logic [31:0] hash_q;
	logic        out_valid_q;
	logic        out_busy;

	sph_pkg::buf_wr_t bwr;
	sph_pkg::ctrl_t   ctl;

	assign out_busy = out_valid_q && !out_ready;

	sph_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_word (data_word),
		.byte_count(byte_count),
		.last      (last),
		.out_busy  (out_busy),
		.bwr       (bwr),
		.ctl       (ctl)
	);

	sph_buf u_buf (
		.clk       (clk),
		.wr        (bwr),
		.rd_idx    (ctl.rd_idx),
		.rd_keep   (ctl.rd_keep),
		.rd_top_en (ctl.rd_top_en),
		.rd_top_val(ctl.rd_top_val),
		.rd_data   (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_first_q  <= '0;
			seed_second_q <= '0;
			const_q       <= sph_pkg::CONST_RESET;
		end else if (write_en) begin
			case (write_index)
				sph_pkg::CFG_SEED_FIRST:  seed_first_q  <= write_data;
				sph_pkg::CFG_SEED_SECOND: seed_second_q <= write_data;
				sph_pkg::CFG_CONST:       const_q       <= write_data;
				default: ;
			endcase
		end
	end

	assign op_a = s_q[ctl.a_pos];

	always_comb begin
		case (ctl.b_src)
			sph_pkg::B_STATE: op_b = s_q[ctl.b_pos];
			sph_pkg::B_DATA:  op_b = rd_data;
			sph_pkg::B_LEN:   op_b = {ctl.len, 56'd0};
			default:          op_b = const_q;
		endcase
	end

	sph_alu u_alu (
		.op(ctl.alu_op),
		.a (op_a),
		.b (op_b),
		.k (ctl.rot_k),
		.y (alu_y)
	);

	// write back, then rotate so the next step's words sit at fixed positions
	always_comb begin
		tmp = s_q;
		if (ctl.wr_en)
			tmp[ctl.dst_pos] = alu_y;
		s_nx = tmp;
		case (ctl.rot_mode)
			sph_pkg::ROT_12: for (int j = 0; j < 12; j++) s_nx[j] = tmp[(j + 1) % 12];
			sph_pkg::ROT_4:  for (int j = 0; j < 4; j++) s_nx[j] = tmp[(j + 1) % 4];
			default: ;
		endcase
		if (ctl.load_long) begin
			for (int j = 0; j < 12; j++) begin
				if (j % 3 == 0)
					s_nx[j] = seed_first_q;
				else if (j % 3 == 1)
					s_nx[j] = seed_second_q;
				else
					s_nx[j] = const_q;
			end
		end
		if (ctl.load_short) begin
			s_nx[0] = seed_first_q;
			s_nx[1] = seed_second_q;
			s_nx[2] = const_q;
			s_nx[3] = const_q;
		end
	end

	always_ff @(posedge clk) begin
		s_q <= s_nx;
		// short path leaves h0 at position 1 after its eleven end steps
		if (ctl.out_load)
			hash_q <= ctl.short_sel ? s_q[1][31:0] : s_q[0][31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (ctl.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	assign out_valid = out_valid_q;
	assign hash      = hash_q;
endmodule

// File: sv/sph_chk.sv
// Port-level checker for the stream hash top level, with its bind.
`include "assert_macros.svh"

module sph_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] hash
);
	`SPH_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(hash), "result lost")
	`SPH_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "double accept")
	`SPH_ASSERT(a_result_then_idle, $rose(out_valid) |-> in_ready, "input side not idle")
	`SPH_ASSERT_NR(a_reset_quiet, !arst_n |=> !out_valid, "result valid after reset")
endmodule

bind spooky_hash_stream_top sph_chk u_sph_chk (.*);
